/* rtl/sebd_pkg.sv */
`default_nettype none
package sebd_pkg;

    localparam int VALUE_W   = 24;
    localparam int LEVEL_W   = 17;
    localparam int CFG_W     = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int DIV_STEPS = VALUE_W;

    localparam int BUCKET_COUNT_DEFAULT  = 8;
    localparam int HISTORY_DEPTH_DEFAULT = 64;

    localparam logic [CFG_W-1:0]   SENSITIVITY_RESET = 16'd4096;
    localparam logic [CFG_W-1:0]   QUIET_FLOOR_RESET = 16'd66;
    localparam logic [LEVEL_W-1:0] ENVELOPE_ONE      = 17'h10000;
    localparam logic [VALUE_W-1:0] VALUE_MAX         = 24'hFFFFFF;

    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_BIN    = 1'b1;

    localparam logic REG_SENSITIVITY = 1'b0;
    localparam logic REG_QUIET_FLOOR = 1'b1;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] beat_level;
        logic               onset;
        logic               quiet;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0] sensitivity;
        logic [CFG_W-1:0] quiet_floor;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

/* rtl/sebd_apb_regs.sv */
`default_nettype none
module sebd_apb_regs
    import sebd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_SENSITIVITY: cfg_next.sensitivity = pwdata[CFG_W-1:0];
                REG_QUIET_FLOOR: cfg_next.quiet_floor = pwdata[CFG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SENSITIVITY: prdata = APB_DW'(cfg_reg.sensitivity);
            REG_QUIET_FLOOR: prdata = APB_DW'(cfg_reg.quiet_floor);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity <= SENSITIVITY_RESET;
            cfg_reg.quiet_floor <= QUIET_FLOOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/sebd_divider.sv */
`default_nettype none
module sebd_divider
    import sebd_pkg::*;
#(
    parameter int DIV_W = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]   divisor,
    output logic                    done,
    output logic      [VALUE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [DIV_W:0]     rem_shift;
    logic               fits;

    assign rem_shift = {rem_reg, quo_reg[VALUE_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        if (start) begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(DIV_STEPS - 1);
            quo_next    = dividend;
            rem_next    = '0;
            div_next    = divisor;
        end else if (active_reg) begin
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            rem_next = fits ? DIV_W'(rem_shift - {1'b0, div_reg}) : rem_shift[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule
`default_nettype wire

/* rtl/spectral_energy_beat_detector.sv */
`default_nettype none
// A magnitude bin of a frame being collected occupies the block from acceptance until the
// 24-step divider is done. The last bin of each bucket then passes through the history read
// and update states; after the last bucket the result goes through the emit state into the
// output register once that register is free. A quiet header also passes through emit.
// After reset the BUCKET_COUNT*HISTORY_DEPTH history entries (512 at the defaults) are
// cleared one entry per cycle, during which s_ready stays low; configuration is taken as ever.
module spectral_energy_beat_detector
    import sebd_pkg::*;
#(
    parameter int BUCKET_COUNT  = BUCKET_COUNT_DEFAULT,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int BKT_IW     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int DIV_W      = $clog2(BUCKET_COUNT + 1);
    localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
    localparam int HIST_SHIFT = $clog2(HISTORY_DEPTH + 1) - 1;
    localparam int MEM_DEPTH  = BUCKET_COUNT * HISTORY_DEPTH;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int PROD_W     = CFG_W + VALUE_W;
    localparam int ENV_W      = LEVEL_W + 2;
    localparam logic [ENV_W-1:0] DECAY_STEP = ENV_W'((4 * 65536) >> HIST_SHIFT);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [MEM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [BKT_IW-1:0]  bucket_reg, bucket_next;
    logic [BKT_IW-1:0]  bin_reg, bin_next;
    logic [VALUE_W-1:0] energy_reg, energy_next;
    logic               onset_seen_reg, onset_seen_next;
    logic               collecting_reg, collecting_next;
    logic [LEVEL_W-1:0] envelope_reg, envelope_next;
    logic               armed_reg, armed_next;
    logic [VALUE_W-1:0] avg_reg [BUCKET_COUNT];
    logic [VALUE_W-1:0] avg_new;
    logic [PROD_W-1:0]  rhs_reg, rhs_next;
    out_word_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;

    logic [VALUE_W-1:0] hist_mem [MEM_DEPTH];
    logic [VALUE_W-1:0] hist_rd_reg;
    logic               mem_we;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [MEM_AW-1:0]  hist_addr;

    logic               div_start;
    logic               div_done;
    logic [VALUE_W-1:0] div_quo;
    logic [DIV_W-1:0]   divisor;

    logic               accept;
    logic               out_free;
    logic               is_quiet;
    logic               last_bucket;
    logic               bucket_onset;
    logic               frame_onset;
    logic [PROD_W-1:0]  lhs;
    logic [VALUE_W-1:0] avg_cur;
    logic [VALUE_W-1:0] avg_sub;
    logic [VALUE_W:0]   avg_sum;
    logic [ENV_W-1:0]   env_ext;
    logic [LEVEL_W-1:0] env_decayed;

    sebd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sebd_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_data.value),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign is_quiet    = s_data.value < VALUE_W'(cfg.quiet_floor);
    assign divisor     = DIV_W'(bucket_reg) + DIV_W'(1);
    assign last_bucket = bucket_reg == BKT_IW'(BUCKET_COUNT - 1);
    assign hist_addr   = MEM_AW'(bucket_reg) * MEM_AW'(HISTORY_DEPTH) + MEM_AW'(slot_reg);
    assign mem_waddr   = (state_reg == S_CLEAR) ? clr_cnt_reg : hist_addr;

    assign avg_cur      = avg_reg[bucket_reg];
    assign lhs          = PROD_W'({energy_reg, 12'b0});
    assign bucket_onset = lhs > rhs_reg;
    assign frame_onset  = onset_seen_reg || bucket_onset;
    assign avg_sub      = avg_cur - (hist_rd_reg >> HIST_SHIFT);
    assign avg_sum      = ((avg_cur > (hist_rd_reg >> HIST_SHIFT)) ? {1'b0, avg_sub} : '0)
                        + {1'b0, energy_reg >> HIST_SHIFT};
    assign avg_new      = avg_sum[VALUE_W] ? VALUE_MAX : avg_sum[VALUE_W-1:0];

    assign env_ext     = ENV_W'(envelope_reg);
    assign env_decayed = !armed_reg ? envelope_reg
                       : (env_ext > DECAY_STEP) ? LEVEL_W'(env_ext - DECAY_STEP) : '0;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_data.func == FUNC_HEADER) begin
                        if (is_quiet) state_next = S_EMIT;
                    end else if (collecting_reg) begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) state_next = (bin_reg == bucket_reg) ? S_READ : S_IDLE;
            end
            S_READ: state_next = S_UPDATE;
            S_UPDATE: state_next = last_bucket ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        s_ready   = state_reg == S_IDLE;
        div_start = (state_reg == S_IDLE) && accept && (s_data.func == FUNC_BIN)
                 && collecting_reg;
        mem_re    = state_reg == S_READ;
        mem_we    = (state_reg == S_CLEAR) || (state_reg == S_UPDATE);
    end

    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        slot_next       = slot_reg;
        bucket_next     = bucket_reg;
        bin_next        = bin_reg;
        energy_next     = energy_reg;
        onset_seen_next = onset_seen_reg;
        collecting_next = collecting_reg;
        envelope_next   = envelope_reg;
        armed_next      = armed_reg;
        rhs_next        = rhs_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        unique case (state_reg)
            S_CLEAR: clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
            S_IDLE: begin
                if (accept && (s_data.func == FUNC_HEADER)) begin
                    bucket_next     = '0;
                    bin_next        = '0;
                    energy_next     = '0;
                    onset_seen_next = 1'b0;
                    collecting_next = !is_quiet;
                    if (is_quiet) begin
                        envelope_next       = env_decayed;
                        res_next.beat_level = env_decayed;
                        res_next.onset      = 1'b0;
                        res_next.quiet      = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    energy_next = energy_reg + div_quo;
                    if (bin_reg != bucket_reg) bin_next = bin_reg + BKT_IW'(1);
                end
            end
            S_READ: rhs_next = PROD_W'(cfg.sensitivity) * PROD_W'(avg_cur);
            S_UPDATE: begin
                onset_seen_next = frame_onset;
                bin_next        = '0;
                energy_next     = '0;
                if (last_bucket) begin
                    bucket_next     = '0;
                    collecting_next = 1'b0;
                    slot_next       = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                    : slot_reg + SLOT_W'(1);
                    res_next.onset  = frame_onset;
                    res_next.quiet  = 1'b0;
                    if (frame_onset && (envelope_reg < ENVELOPE_ONE)) begin
                        envelope_next       = ENVELOPE_ONE;
                        armed_next          = 1'b1;
                        res_next.beat_level = ENVELOPE_ONE;
                    end else begin
                        envelope_next       = env_decayed;
                        res_next.beat_level = env_decayed;
                    end
                end else begin
                    bucket_next = bucket_reg + BKT_IW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: clr_cnt_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            slot_reg       <= '0;
            bucket_reg     <= '0;
            bin_reg        <= '0;
            energy_reg     <= '0;
            onset_seen_reg <= 1'b0;
            collecting_reg <= 1'b0;
            envelope_reg   <= '0;
            armed_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            slot_reg       <= slot_next;
            bucket_reg     <= bucket_next;
            bin_reg        <= bin_next;
            energy_reg     <= energy_next;
            onset_seen_reg <= onset_seen_next;
            collecting_reg <= collecting_next;
            envelope_reg   <= envelope_next;
            armed_reg      <= armed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUCKET_COUNT; i++) avg_reg[i] <= '0;
        end else if (state_reg == S_UPDATE) begin
            avg_reg[bucket_reg] <= avg_new;
        end
    end

    always_ff @(posedge aclk) begin
        rhs_reg    <= rhs_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) hist_mem[mem_waddr] <= (state_reg == S_CLEAR) ? '0 : energy_reg;
        if (mem_re) hist_rd_reg <= hist_mem[hist_addr];
    end

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");
    a_envelope_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        envelope_reg <= ENVELOPE_ONE)
        else $error("envelope above one");
    a_quiet_no_onset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.quiet |-> !m_data_reg.onset)
        else $error("quiet word carries an onset");
    a_no_word_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !m_valid_reg && !s_ready)
        else $error("handshake active during history clear");
`endif

endmodule
`default_nettype wire
